FILE: rtl/core/hcs_pkg.sv
// ----------------------------------------------------------------------------
// hcs_pkg
// Shared constants and types of the Hamiltonian cycle search block.
// ----------------------------------------------------------------------------
package hcs_pkg;

  // Graph size and derived widths
  localparam int VERTICES = 16;
  localparam int VIDX_W   = $clog2(VERTICES);      // vertex number
  localparam int VCNT_W   = $clog2(VERTICES + 1);  // depth / candidate count
  localparam int ROW_W    = VERTICES;              // one adjacency row

  localparam logic [VCNT_W-1:0] VCNT_MAX = VCNT_W'(VERTICES);

  // Stream payload layout
  localparam int S_FIELD_W = 4 + 16 + 4;           // row_index, row_bits, start_vertex
  localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
  localparam int M_FIELD_W = 4;                    // vertex
  localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

  // Item kinds on the input stream
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  // Row write into the adjacency store
  typedef struct packed {
    logic              en;
    logic [VIDX_W-1:0] addr;
    logic [ROW_W-1:0]  data;
  } adj_wr_t;

  // Edge query: current path end and candidate vertex
  typedef struct packed {
    logic [VIDX_W-1:0] prev;
    logic [VIDX_W-1:0] cand;
  } adj_rd_t;

endpackage

FILE: rtl/core/hcs_ram.sv
// ----------------------------------------------------------------------------
// hcs_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module hcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: rtl/core/hcs_adj.sv
// ----------------------------------------------------------------------------
// hcs_adj
// Adjacency store with per-row valid bits; answers one undirected edge
// query per fetch (either direction's bit counts).
// ----------------------------------------------------------------------------
module hcs_adj
  import hcs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  adj_wr_t wr_i,
  input  adj_rd_t rd_i,     // held stable from fetch to evaluate
  output logic    linked_o
);

  logic [VERTICES-1:0] row_vld_q;
  logic [ROW_W-1:0]    row_prev;
  logic [ROW_W-1:0]    row_cand;

  hcs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (VERTICES)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (wr_i.en),
    .waddr_i   (wr_i.addr),
    .wdata_i   (wr_i.data),
    .raddr_a_i (rd_i.prev),
    .raddr_b_i (rd_i.cand),
    .rdata_a_o (row_prev),
    .rdata_b_o (row_cand)
  );

  // Rows never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (wr_i.en) begin
      row_vld_q[wr_i.addr] <= 1'b1;
    end
  end

  assign linked_o = (row_vld_q[rd_i.prev] & row_prev[rd_i.cand]) |
                    (row_vld_q[rd_i.cand] & row_cand[rd_i.prev]);

endmodule

FILE: rtl/core/hcs_search.sv
// ----------------------------------------------------------------------------
// hcs_search
// Backtracking sequencer: explicit path / resume stacks, visit marks, one
// candidate edge test per fetch-evaluate pair, and the result register.
// ----------------------------------------------------------------------------
module hcs_search
  import hcs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,        // search item accepted
  input  logic [VIDX_W-1:0] start_vertex_i,
  output logic              ready_o,
  output adj_rd_t           adj_rd_o,
  input  logic              linked_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [VIDX_W-1:0] vertex_o,
  output logic              found_o,
  output logic              last_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_EMIT,
    ST_FAIL
  } state_e;

  state_e              state_q;
  logic [VCNT_W-1:0]   depth_q;
  logic [VCNT_W-1:0]   cand_q;
  logic [VCNT_W-1:0]   out_idx_q;
  logic [VIDX_W-1:0]   start_q;
  logic [VERTICES-1:0] visited_q;
  logic [VIDX_W-1:0]   path_q [VERTICES];
  logic [VCNT_W-1:0]   res_q  [VERTICES];

  logic                m_valid_q;
  logic [VIDX_W-1:0]   vertex_q;
  logic                found_q;
  logic                last_q;

  logic [VCNT_W-1:0]   depth_m1;
  logic [VIDX_W-1:0]   rd_idx;
  logic [VIDX_W-1:0]   prev;
  logic                cand_done;
  logic                full;
  logic                advance;
  logic                closes;
  logic                out_free;
  logic                emit_fire;

  // Path read port: path end while searching, emit index while emitting
  assign depth_m1  = depth_q - VCNT_W'(1);
  assign rd_idx    = (state_q == ST_EMIT) ? out_idx_q[VIDX_W-1:0] : depth_m1[VIDX_W-1:0];
  assign prev      = path_q[rd_idx];

  assign cand_done = (cand_q == VCNT_MAX);
  assign full      = (depth_q == VCNT_MAX);
  assign advance   = !cand_done && linked_i && !full && !visited_q[cand_q[VIDX_W-1:0]];
  assign closes    = !cand_done && linked_i && full && (cand_q[VIDX_W-1:0] == start_q);
  assign out_free  = !m_valid_q || m_ready_i;
  assign emit_fire = ((state_q == ST_EMIT) || (state_q == ST_FAIL)) && out_free;

  assign adj_rd_o.prev = prev;
  assign adj_rd_o.cand = cand_q[VIDX_W-1:0];

  // Sequencer, visit marks and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      depth_q   <= '0;
      cand_q    <= '0;
      out_idx_q <= '0;
      start_q   <= '0;
      visited_q <= '0;
      m_valid_q <= 1'b0;
      vertex_q  <= '0;
      found_q   <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      // Output valid: set when a result is loaded, cleared when taken
      if (emit_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            start_q   <= start_vertex_i;
            visited_q <= {{(VERTICES-1){1'b0}}, 1'b1} << start_vertex_i;
            depth_q   <= VCNT_W'(1);
            cand_q    <= '0;
            state_q   <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (cand_done) begin
            // level exhausted: backtrack or give up
            if (depth_q <= VCNT_W'(1)) begin
              state_q <= ST_FAIL;
            end else begin
              visited_q[prev] <= 1'b0;
              depth_q <= depth_m1;
              cand_q  <= res_q[depth_m1[VIDX_W-1:0]];
              state_q <= ST_FETCH;
            end
          end else if (closes) begin
            out_idx_q <= '0;
            state_q   <= ST_EMIT;
          end else if (advance) begin
            visited_q[cand_q[VIDX_W-1:0]] <= 1'b1;
            depth_q <= depth_q + VCNT_W'(1);
            cand_q  <= '0;
            state_q <= ST_FETCH;
          end else begin
            cand_q  <= cand_q + VCNT_W'(1);
            state_q <= ST_FETCH;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            vertex_q  <= (out_idx_q == VCNT_MAX) ? start_q : prev;
            found_q   <= 1'b1;
            last_q    <= (out_idx_q == VCNT_MAX);
            out_idx_q <= out_idx_q + VCNT_W'(1);
            if (out_idx_q == VCNT_MAX) begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_FAIL: begin
          if (out_free) begin
            vertex_q  <= '0;
            found_q   <= 1'b0;
            last_q    <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Path and resume stacks
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      path_q[0] <= start_vertex_i;
    end
    if (state_q == ST_EVAL && advance) begin
      path_q[depth_q[VIDX_W-1:0]] <= cand_q[VIDX_W-1:0];
      res_q[depth_q[VIDX_W-1:0]]  <= cand_q + VCNT_W'(1);
    end
  end

  assign ready_o   = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;
  assign vertex_o  = vertex_q;
  assign found_o   = found_q;
  assign last_o    = last_q;

endmodule

FILE: rtl/core/hamiltonian_cycle_search.sv
// ----------------------------------------------------------------------------
// hamiltonian_cycle_search
// Adjacency row loader and depth-first Hamiltonian cycle search.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser selects the item kind. A load item writes one
// adjacency row and is taken every cycle while idle; it gives no result. A
// search item looks for a cycle through all vertices from start_vertex; an
// edge exists if either direction's bit is set, and neighbors are tried in
// ascending order.
// Output stream (m_axis): on success the path vertices in visit order, then
// the start vertex again with tlast; tuser (found) is high on all. On failure
// one item with found low, vertex zero and tlast high.
// Timing: each fetch-evaluate pair (adjacency RAM fetch, then evaluate)
// covers one candidate test or one exhausted level; the number of pairs
// is data dependent. After the search item is accepted, ready stays low
// until the last result is in the output register. Results leave one per
// cycle while the receiver takes them; a stall holds the result register
// and the sequencer waits. The last result may still wait while the next
// item is accepted. Reset clears the adjacency valid bits (all rows read
// as zero), the visit marks and the output valid; ready is high once reset
// is released.
// ----------------------------------------------------------------------------
module hamiltonian_cycle_search
  import hcs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // row_index, row_bits, start_vertex
  input  logic                 s_axis_tuser,   // op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // vertex
  output logic                 m_axis_tuser,   // found
  output logic                 m_axis_tlast    // last
);

  logic              s_accept;
  logic [VIDX_W-1:0] row_index;
  logic [ROW_W-1:0]  row_bits;
  logic [VIDX_W-1:0] start_vertex;
  adj_wr_t           adj_wr;
  adj_rd_t           adj_rd;
  logic              linked;
  logic [VIDX_W-1:0] vertex;

  // Input item decode
  assign s_accept     = s_axis_tvalid && s_axis_tready;
  assign row_index    = s_axis_tdata[3:0];
  assign row_bits     = s_axis_tdata[19:4];
  assign start_vertex = s_axis_tdata[23:20];

  assign adj_wr.en   = s_accept && (s_axis_tuser == OP_LOAD) &&
                       ({1'b0, row_index} < VCNT_MAX);
  assign adj_wr.addr = row_index;
  assign adj_wr.data = row_bits;

  hcs_adj u_adj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (adj_wr),
    .rd_i     (adj_rd),
    .linked_o (linked)
  );

  hcs_search u_search (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (s_accept && (s_axis_tuser == OP_SEARCH)),
    .start_vertex_i (start_vertex),
    .ready_o        (s_axis_tready),
    .adj_rd_o       (adj_rd),
    .linked_i       (linked),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .vertex_o       (vertex),
    .found_o        (m_axis_tuser),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {{(M_TDATA_W - VIDX_W){1'b0}}, vertex};

`ifndef SYNTH
  // A search keeps the input side closed on the following cycle
  a_search_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_SEARCH)) |=> !s_axis_tready)
    else $error("input ready right after a search item");

  // A failure report is a single closing item with vertex zero
  a_fail_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == '0)))
    else $error("malformed failure result");

  // Results only appear while the sequencer is busy or just finished
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready) || $past(m_axis_tvalid))
    else $error("result raised from an idle sequencer");
`endif

endmodule
